[sv/rlpse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpse_pkg
// shared types and constants of the rgb led pulse symbol encoder
// ----------------------------------------------------------------------------
package rlpse_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned TICK_W      = 15;
  localparam int unsigned SYM_PER_PIX = 3 * CHAN_W;
  localparam int unsigned CNT_W       = $clog2(SYM_PER_PIX);
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = TICK_W;

  localparam logic [TICK_W-1:0] TICK_MAX  = 15'h7FFF;
  localparam logic [CNT_W-1:0]  LAST_SYM  = CNT_W'(SYM_PER_PIX - 1);

  // reset values of the configuration registers
  localparam logic [CHAN_W-1:0] BRIGHT_RST    = 8'd255;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 15'd8;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 15'd16;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 15'd17;
  localparam logic [TICK_W-1:0] ONE_LOW_RST   = 15'd9;
  localparam logic [TICK_W-1:0] LATCH_RST     = TICK_W'(300000 / 50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_ZERO_HIGH  = 3'd1,
    REG_ONE_HIGH   = 3'd2,
    REG_ZERO_LOW   = 3'd3,
    REG_ONE_LOW    = 3'd4,
    REG_LATCH      = 3'd5
  } cfg_reg_e;

  // pulse timing set handed to the symbol stage
  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] latch;
  } tick_cfg_t;

  // one emitted pulse symbol
  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic              pixel_done;
    logic              frame_done;
  } sym_t;

endpackage

[sv/rlpse_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpse interfaces
// pixel input channel and pulse symbol output channel
// ----------------------------------------------------------------------------
interface rlpse_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [rlpse_pkg::CHAN_W-1:0] red;
  logic [rlpse_pkg::CHAN_W-1:0] green;
  logic [rlpse_pkg::CHAN_W-1:0] blue;
  logic                       frame_last_pixel;

  modport source (output valid, red, green, blue, frame_last_pixel, input ready);
  modport sink   (input valid, red, green, blue, frame_last_pixel, output ready);
endinterface

interface rlpse_symbol_if;
  logic                       valid;
  logic                       ready;
  logic [rlpse_pkg::TICK_W-1:0] high_ticks;
  logic [rlpse_pkg::TICK_W-1:0] low_ticks;
  logic                       pixel_done;
  logic                       frame_done;

  modport source (output valid, high_ticks, low_ticks, pixel_done, frame_done,
                  input ready);
  modport sink   (input valid, high_ticks, low_ticks, pixel_done, frame_done,
                  output ready);
endinterface

[sv/rlpse_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpse_lane
// one colour channel lane: brightness gain, product shifted right by eight
// ----------------------------------------------------------------------------
module rlpse_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [rlpse_pkg::CHAN_W-1:0] value_i,
  input  logic [rlpse_pkg::CHAN_W-1:0] bright_i,
  output logic [rlpse_pkg::CHAN_W-1:0] scaled_o
);
  import rlpse_pkg::*;

  logic [2*CHAN_W-1:0] prod;
  logic [CHAN_W-1:0]   scaled_q;

  assign prod = {{CHAN_W{1'b0}}, value_i} * {{CHAN_W{1'b0}}, bright_i};

  // truncating scale keeps the upper byte
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scaled_q <= prod[2*CHAN_W-1:CHAN_W];
    end
  end

  assign scaled_o = scaled_q;

endmodule

[sv/rlpse_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpse_serializer
// merges lane bytes as green, red, blue; one symbol per cycle unless stalled
// ----------------------------------------------------------------------------
module rlpse_serializer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rlpse_pkg::tick_cfg_t         tick_cfg_i,
  input  logic                         word_valid_i,
  input  logic [rlpse_pkg::CHAN_W-1:0] red_i,
  input  logic [rlpse_pkg::CHAN_W-1:0] green_i,
  input  logic [rlpse_pkg::CHAN_W-1:0] blue_i,
  input  logic                         last_i,
  output logic                         word_ready_o,
  output logic                         sym_valid_o,
  input  logic                         sym_ready_i,
  output rlpse_pkg::sym_t              sym_o
);
  import rlpse_pkg::*;

  logic                   busy_q, busy_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SYM_PER_PIX-1:0] word_q;
  logic                   last_q;
  logic                   out_valid_q;
  sym_t                   sym_q, sym_d;

  logic              advance, last_bit, load, emit, cur_one, frame_end;
  logic [TICK_W-1:0] lo_sel;
  logic [TICK_W:0]   lo_sum;

  assign advance      = !out_valid_q || sym_ready_i;
  assign last_bit     = (cnt_q == LAST_SYM);
  assign word_ready_o = !busy_q || (advance && last_bit);
  assign load         = word_valid_i && word_ready_o;
  assign emit         = busy_q && advance;

  assign cur_one   = word_q[SYM_PER_PIX-1];
  assign frame_end = last_bit && last_q;
  assign lo_sel    = cur_one ? tick_cfg_i.one_low : tick_cfg_i.zero_low;
  assign lo_sum    = {1'b0, lo_sel} + {1'b0, tick_cfg_i.latch};

  always_comb begin
    sym_d.high_ticks = cur_one ? tick_cfg_i.one_high : tick_cfg_i.zero_high;
    sym_d.pixel_done = last_bit;
    sym_d.frame_done = frame_end;
    if (frame_end) begin
      sym_d.low_ticks = lo_sum[TICK_W] ? TICK_MAX : lo_sum[TICK_W-1:0];
    end else begin
      sym_d.low_ticks = lo_sel;
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (emit) begin
      busy_d = !last_bit;
      cnt_d  = CNT_W'(cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (advance) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= {green_i, red_i, blue_i};
      last_q <= last_i;
    end else if (emit) begin
      word_q <= {word_q[SYM_PER_PIX-2:0], 1'b0};
    end
    if (emit) begin
      sym_q <= sym_d;
    end
  end

  assign sym_valid_o = out_valid_q;
  assign sym_o       = sym_q;

  a_frame_implies_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sym_q.frame_done) |-> sym_q.pixel_done)
    else $error("frame_done without pixel_done");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= LAST_SYM))
    else $error("symbol counter out of range");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_bit && !load) |=> !busy_q)
    else $error("serializer still busy after the last symbol");

  a_no_load_midrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !last_bit) |-> !load)
    else $error("new word loaded in the middle of a pixel");

endmodule

[sv/rgb_led_pulse_symbol_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pulse_symbol_encoder_core
// pixel to led pulse symbol encoder with brightness scaling
// ----------------------------------------------------------------------------
// Each accepted pixel produces 24 pulse symbols, one per clock while the
// output accepts them, in the order green, red, blue, msb first; the symbol
// serializer, which emits a single symbol per cycle unless the output stalls,
// sets the pixel rate. Three lanes scale the channels in parallel in the cycle
// after acceptance, and a pixel passes the lane registers, the serializer word
// register and the output symbol register before its first symbol appears. One
// pixel waits in the lane registers while the previous one is serialized, and
// the next pixel's word is taken the same cycle the last symbol of the previous
// pixel leaves, so no gap is inserted between pixels. Configuration writes are
// expected only while the block is idle; writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module rgb_led_pulse_symbol_encoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rlpse_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rlpse_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  rlpse_pixel_if.sink                       pix_i,
  rlpse_symbol_if.source                    sym_o
);
  import rlpse_pkg::*;

  // configuration registers
  logic [CHAN_W-1:0] bright_q;
  tick_cfg_t         tick_cfg_q;

  // lane stage control
  logic              s1_valid_q;
  logic              s1_last_q;
  logic              in_acc;
  logic              word_ready;

  // scaled channel bytes from the lanes
  logic [CHAN_W-1:0] red_s, green_s, blue_s;

  sym_t              sym;
  logic              sym_valid;

  // register writes, unknown index leaves everything as is
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q             <= BRIGHT_RST;
      tick_cfg_q.zero_high <= ZERO_HIGH_RST;
      tick_cfg_q.one_high  <= ONE_HIGH_RST;
      tick_cfg_q.zero_low  <= ZERO_LOW_RST;
      tick_cfg_q.one_low   <= ONE_LOW_RST;
      tick_cfg_q.latch     <= LATCH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BRIGHTNESS: bright_q             <= cfg_wdata_i[CHAN_W-1:0];
        REG_ZERO_HIGH:  tick_cfg_q.zero_high <= cfg_wdata_i;
        REG_ONE_HIGH:   tick_cfg_q.one_high  <= cfg_wdata_i;
        REG_ZERO_LOW:   tick_cfg_q.zero_low  <= cfg_wdata_i;
        REG_ONE_LOW:    tick_cfg_q.one_low   <= cfg_wdata_i;
        REG_LATCH:      tick_cfg_q.latch     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // lane stage takes a pixel when empty or when its pixel moves on
  assign pix_i.ready = !s1_valid_q || word_ready;
  assign in_acc      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (word_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_last_q <= pix_i.frame_last_pixel;
    end
  end

  // three parallel scaling lanes
  rlpse_lane u_lane_red (
    .clk_i    (clk_i),
    .en_i     (in_acc),
    .value_i  (pix_i.red),
    .bright_i (bright_q),
    .scaled_o (red_s)
  );

  rlpse_lane u_lane_green (
    .clk_i    (clk_i),
    .en_i     (in_acc),
    .value_i  (pix_i.green),
    .bright_i (bright_q),
    .scaled_o (green_s)
  );

  rlpse_lane u_lane_blue (
    .clk_i    (clk_i),
    .en_i     (in_acc),
    .value_i  (pix_i.blue),
    .bright_i (bright_q),
    .scaled_o (blue_s)
  );

  // merge into the grb word and emit symbols
  rlpse_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_cfg_i   (tick_cfg_q),
    .word_valid_i (s1_valid_q),
    .red_i        (red_s),
    .green_i      (green_s),
    .blue_i       (blue_s),
    .last_i       (s1_last_q),
    .word_ready_o (word_ready),
    .sym_valid_o  (sym_valid),
    .sym_ready_i  (sym_o.ready),
    .sym_o        (sym)
  );

  assign sym_o.valid      = sym_valid;
  assign sym_o.high_ticks = sym.high_ticks;
  assign sym_o.low_ticks  = sym.low_ticks;
  assign sym_o.pixel_done = sym.pixel_done;
  assign sym_o.frame_done = sym.frame_done;

endmodule
